// ===== hw/rtl/scsd_pkg.sv =====
// Shared types, key codes and character tables for the set-1 scan byte decoder.
// No dependencies; every other file in the block imports this package.

package scsd_pkg;

	// Key event codes carried on event_kind.
	typedef enum logic [4:0] {
		EV_NONE      = 5'd0,
		EV_CHAR      = 5'd1,
		EV_BACKSPACE = 5'd2,
		EV_TAB       = 5'd3,
		EV_HOME      = 5'd4,
		EV_END       = 5'd5,
		EV_UP        = 5'd6,
		EV_DOWN      = 5'd7,
		EV_LEFT      = 5'd8,
		EV_RIGHT     = 5'd9,
		EV_PGUP      = 5'd10,
		EV_PGDN      = 5'd11,
		EV_INSERT    = 5'd12,
		EV_DELETE    = 5'd13,
		EV_CAPS      = 5'd14,
		EV_HELP      = 5'd15,
		EV_SAVE      = 5'd16,
		EV_UNDO      = 5'd17,
		EV_EXIT      = 5'd18
	} event_kind_t;

	// One decoded result as it moves from the decoder to the output register.
	typedef struct packed {
		event_kind_t kind;
		logic [6:0]  char_code;
		logic        caps_on;
	} key_result_t;

	// Special bytes and make codes.
	localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
	localparam logic [7:0] ESC_RELEASE  = 8'h81;
	localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT   = 7'h36;
	localparam logic [6:0] KEY_CTRL     = 7'h1D;
	localparam logic [6:0] KEY_CAPS     = 7'h3A;
	localparam logic [6:0] KEY_F1       = 7'h3B;
	localparam logic [6:0] KEY_F2       = 7'h3C;
	localparam logic [6:0] KEY_S        = 7'h1F;
	localparam logic [6:0] KEY_Z        = 7'h2C;
	localparam logic [6:0] KEY_BKSP     = 7'h0E;
	localparam logic [6:0] KEY_ENTER    = 7'h1C;
	localparam logic [6:0] KEY_TAB      = 7'h0F;
	localparam logic [6:0] KEY_HOME     = 7'h47;
	localparam logic [6:0] KEY_END      = 7'h4F;
	localparam logic [6:0] KEY_UP       = 7'h48;
	localparam logic [6:0] KEY_DOWN     = 7'h50;
	localparam logic [6:0] KEY_LEFT     = 7'h4B;
	localparam logic [6:0] KEY_RIGHT    = 7'h4D;
	localparam logic [6:0] KEY_PGUP     = 7'h49;
	localparam logic [6:0] KEY_PGDN     = 7'h51;
	localparam logic [6:0] KEY_INSERT   = 7'h52;
	localparam logic [6:0] KEY_DELETE   = 7'h53;
	localparam logic [6:0] ASCII_LF     = 7'h0A;
	localparam logic [6:0] ASCII_SPACE  = 7'h20;
	localparam logic [6:0] CASE_OFFSET  = 7'h20;

	// Unshifted character for a make code; zero where the key has no character.
	function automatic logic [6:0] base_char(input logic [6:0] code);
		logic [6:0] c;
		case (code)
			7'h02: c = 7'h31;
			7'h03: c = 7'h32;
			7'h04: c = 7'h33;
			7'h05: c = 7'h34;
			7'h06: c = 7'h35;
			7'h07: c = 7'h36;
			7'h08: c = 7'h37;
			7'h09: c = 7'h38;
			7'h0A: c = 7'h39;
			7'h0B: c = 7'h30;
			7'h0C: c = 7'h2D;
			7'h0D: c = 7'h3D;
			7'h10: c = 7'h71;
			7'h11: c = 7'h77;
			7'h12: c = 7'h65;
			7'h13: c = 7'h72;
			7'h14: c = 7'h74;
			7'h15: c = 7'h79;
			7'h16: c = 7'h75;
			7'h17: c = 7'h69;
			7'h18: c = 7'h6F;
			7'h19: c = 7'h70;
			7'h1A: c = 7'h5B;
			7'h1B: c = 7'h5D;
			7'h1E: c = 7'h61;
			7'h1F: c = 7'h73;
			7'h20: c = 7'h64;
			7'h21: c = 7'h66;
			7'h22: c = 7'h67;
			7'h23: c = 7'h68;
			7'h24: c = 7'h6A;
			7'h25: c = 7'h6B;
			7'h26: c = 7'h6C;
			7'h27: c = 7'h3B;
			7'h28: c = 7'h27;
			7'h2B: c = 7'h5C;
			7'h2C: c = 7'h7A;
			7'h2D: c = 7'h78;
			7'h2E: c = 7'h63;
			7'h2F: c = 7'h76;
			7'h30: c = 7'h62;
			7'h31: c = 7'h6E;
			7'h32: c = 7'h6D;
			7'h33: c = 7'h2C;
			7'h34: c = 7'h2E;
			7'h35: c = 7'h2F;
			7'h39: c = ASCII_SPACE;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	// Shifted form of a symbol; only the '1' key shifts among the digits.
	function automatic logic [6:0] shift_symbol(input logic [6:0] c);
		logic [6:0] s;
		case (c)
			7'h31: s = 7'h21;
			7'h2D: s = 7'h5F;
			7'h3D: s = 7'h2B;
			7'h5B: s = 7'h7B;
			7'h5D: s = 7'h7D;
			7'h3B: s = 7'h3A;
			7'h27: s = 7'h22;
			7'h5C: s = 7'h7C;
			7'h2C: s = 7'h3C;
			7'h2E: s = 7'h3E;
			7'h2F: s = 7'h3F;
			default: s = c;
		endcase
		return s;
	endfunction

	// Navigation event for an extended make code.
	function automatic event_kind_t extended_event(input logic [6:0] code);
		event_kind_t ev;
		case (code)
			KEY_HOME:   ev = EV_HOME;
			KEY_END:    ev = EV_END;
			KEY_UP:     ev = EV_UP;
			KEY_DOWN:   ev = EV_DOWN;
			KEY_LEFT:   ev = EV_LEFT;
			KEY_RIGHT:  ev = EV_RIGHT;
			KEY_PGUP:   ev = EV_PGUP;
			KEY_PGDN:   ev = EV_PGDN;
			KEY_INSERT: ev = EV_INSERT;
			KEY_DELETE: ev = EV_DELETE;
			default:    ev = EV_NONE;
		endcase
		return ev;
	endfunction

endpackage

// ===== hw/rtl/scsd_decode.sv =====
// Decode stage: modifier and prefix flags plus the combinational byte decoder.
// Depends on scsd_pkg for key codes, tables and the result struct.

module scsd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           scan_byte_s1,
	output scsd_pkg::key_result_t result
);
	import scsd_pkg::*;

	logic ext_q, lshift_q, rshift_q, ctrl_q, caps_q;
	logic ext_d, lshift_d, rshift_d, ctrl_d, caps_d;
	logic [6:0] code;
	logic brk;
	logic shift;
	logic letter;
	logic [6:0] base_c;
	logic [6:0] key_c;
	event_kind_t ev;
	logic [6:0] ch;

	assign code  = scan_byte_s1[6:0];
	assign brk   = scan_byte_s1[7];
	assign shift = lshift_q | rshift_q;

	// Printable character for a plain make code, with shift and caps applied.
	always_comb begin
		base_c = base_char(code);
		letter = code inside {[7'h10:7'h19], [7'h1E:7'h26], [7'h2C:7'h32]};
		if (base_c == 7'h00 || base_c == ASCII_SPACE) begin
			key_c = base_c;
		end else if (letter) begin
			key_c = (shift ^ caps_q) ? (base_c - CASE_OFFSET) : base_c;
		end else begin
			key_c = shift ? shift_symbol(base_c) : base_c;
		end
	end

	// Byte classification in priority order, with the next flag values.
	always_comb begin
		ext_d    = ext_q;
		lshift_d = lshift_q;
		rshift_d = rshift_q;
		ctrl_d   = ctrl_q;
		caps_d   = caps_q;
		ev       = EV_NONE;
		ch       = 7'h00;
		if (scan_byte_s1 == PREFIX_BYTE) begin
			ext_d = 1'b1;
		end else if (ext_q) begin
			ext_d = 1'b0;
			if (!brk) begin
				ev = extended_event(code);
			end
		end else if (code == KEY_LSHIFT) begin
			lshift_d = !brk;
		end else if (code == KEY_RSHIFT) begin
			rshift_d = !brk;
		end else if (code == KEY_CTRL) begin
			ctrl_d = !brk;
		end else if (scan_byte_s1 == ESC_RELEASE) begin
			ev = EV_EXIT;
		end else if (brk) begin
			ev = EV_NONE;
		end else if (code == KEY_CAPS) begin
			caps_d = !caps_q;
			ev     = EV_CAPS;
		end else if (code == KEY_F1) begin
			ev = EV_HELP;
		end else if (code == KEY_F2 || (ctrl_q && code == KEY_S)) begin
			ev = EV_SAVE;
		end else if (ctrl_q && code == KEY_Z) begin
			ev = EV_UNDO;
		end else if (code == KEY_BKSP) begin
			ev = EV_BACKSPACE;
		end else if (code == KEY_ENTER) begin
			ev = EV_CHAR;
			ch = ASCII_LF;
		end else if (code == KEY_TAB) begin
			ev = EV_TAB;
		end else if (key_c != 7'h00) begin
			ev = EV_CHAR;
			ch = key_c;
		end
	end

	// Flags advance only when the byte moves on to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q    <= 1'b0;
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			ctrl_q   <= 1'b0;
			caps_q   <= 1'b0;
		end else if (step) begin
			ext_q    <= ext_d;
			lshift_q <= lshift_d;
			rshift_q <= rshift_d;
			ctrl_q   <= ctrl_d;
			caps_q   <= caps_d;
		end
	end

	assign result.kind      = ev;
	assign result.char_code = ch;
	assign result.caps_on   = caps_d;

endmodule

// ===== hw/rtl/scsd_out_buf.sv =====
// Output register with valid/stall handshake toward the event consumer.
// Depends on scsd_pkg for the result struct.

module scsd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load_valid,
	input  scsd_pkg::key_result_t load_data,
	output logic                 load_ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           event_kind,
	output logic [6:0]           char_code,
	output logic                 caps_on
);
	import scsd_pkg::*;

	logic        valid_q;
	key_result_t data_q;

	// The register can take a new result when it is empty or its transaction completes.
	assign load_ready = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load_valid) begin
			data_q <= load_data;
		end
	end

	assign out_valid  = valid_q;
	assign event_kind = data_q.kind;
	assign char_code  = data_q.char_code;
	assign caps_on    = data_q.caps_on;

endmodule

// ===== hw/rtl/scancode_set1_key_decoder_core.sv =====
// Set-1 keyboard scan byte decoder, one key event per scan byte.
// Each accepted byte passes the input register, the decoder and the output register.
// One byte per cycle while out_stall is low; input and output register each hold one byte.
// Reset (arst_n low, asynchronous) clears both valid bits and all modifier/prefix flags.
// Depends on scsd_pkg, scsd_decode and scsd_out_buf.

module scancode_set1_key_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] event_kind,
	output logic [6:0] char_code,
	output logic       caps_on
);
	import scsd_pkg::*;

	logic        valid_s1;
	logic [7:0]  scan_byte_s1;
	logic        adv;
	logic        step;
	key_result_t result;

	// Input register moves whenever the output register takes its byte.
	assign in_stall = valid_s1 && !adv;
	assign step     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			scan_byte_s1 <= scan_byte;
		end
	end

	// Decoder with its flag registers.
	scsd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.scan_byte_s1 (scan_byte_s1),
		.result       (result)
	);

	// Result register toward the consumer.
	scsd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_data  (result),
		.load_ready (adv),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.char_code  (char_code),
		.caps_on    (caps_on)
	);

endmodule

// ===== hw/rtl/scsd_checker.sv =====
// Port-level checks for the scan byte decoder, bound to the top level.
// Depends on scsd_pkg for the event codes.

module scsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] event_kind,
	input logic [6:0] char_code,
	input logic       caps_on
);
	import scsd_pkg::*;

	// Codes above EV_EXIT are never produced.
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind <= EV_EXIT))
		else $error("event_kind out of range");

	// A character code appears only with a character event.
	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind != EV_CHAR) |-> (char_code == 7'h00))
		else $error("char_code set on a non-character event");

	// A character event always carries a nonzero code.
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_kind == EV_CHAR) |-> (char_code != 7'h00))
		else $error("character event with zero code");

	// A stalled result holds until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_kind)
			&& $stable(char_code) && $stable(caps_on)))
		else $error("stalled result changed");

	// The input stalls only while a waiting result is itself stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with the output free");

endmodule

bind scancode_set1_key_decoder_core scsd_checker u_scsd_checker (.*);

// ===== tb/sv/scancode_set1_key_decoder_core_test.sv =====
// Self-checking testbench for scancode_set1_key_decoder_core: directed and random scan bytes.
// It predicts each key event and caps state, then checks every output transaction in order.
// Depends on scsd_pkg and the scancode_set1_key_decoder_core RTL.
`timescale 1ns / 1ps

module scancode_set1_key_decoder_core_test;
	import scsd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [6:0] KEY_ESC = 7'h01;
	localparam logic [6:0] KEY_ONE = 7'h02;
	localparam logic [6:0] KEY_A = 7'h1E;
	localparam logic [6:0] KEY_E = 7'h12;
	localparam logic [6:0] KEY_SPACE = 7'h39;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] scan_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] event_kind;
	logic [6:0] char_code;
	logic caps_on;

	// Bytes waiting to be offered and key events waiting to come out.
	logic [7:0] scan_queue[$];
	key_result_t expected_events[$];

	// Predicted keyboard state.
	logic ext_pending = 1'b0;
	logic lshift_held = 1'b0;
	logic rshift_held = 1'b0;
	logic ctrl_held = 1'b0;
	logic caps_locked = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_count = 0;
	int idle_cycles = 0;
	int error_count = 0;

	scancode_set1_key_decoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.scan_byte(scan_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.char_code(char_code),
		.caps_on(caps_on)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Navigation event for a make code that follows the extended prefix.
	function automatic event_kind_t nav_event(input logic [6:0] k);
		event_kind_t ev;
		case (k)
			KEY_HOME:   ev = EV_HOME;
			KEY_END:    ev = EV_END;
			KEY_UP:     ev = EV_UP;
			KEY_DOWN:   ev = EV_DOWN;
			KEY_LEFT:   ev = EV_LEFT;
			KEY_RIGHT:  ev = EV_RIGHT;
			KEY_PGUP:   ev = EV_PGUP;
			KEY_PGDN:   ev = EV_PGDN;
			KEY_INSERT: ev = EV_INSERT;
			KEY_DELETE: ev = EV_DELETE;
			default:    ev = EV_NONE;
		endcase
		return ev;
	endfunction

	// Character typed by a make code, or zero when the key prints nothing.
	function automatic logic [6:0] typed_char(input logic [6:0] k, input logic shifted,
			input logic caps);
		string digits_row = "1234567890-=";
		string top_row = "qwertyuiop[]";
		string home_row = "asdfghjkl;'";
		string bottom_row = "\\zxcvbnm,./";
		string shift_from = "1-=[];'\\,./";
		string shift_to = "!_+{}:\"|<>?";
		logic [7:0] c;
		c = 8'h00;
		if (k >= 7'h02 && k <= 7'h0D)
			c = digits_row[int'(k) - 2];
		else if (k >= 7'h10 && k <= 7'h1B)
			c = top_row[int'(k) - 16];
		else if (k >= 7'h1E && k <= 7'h28)
			c = home_row[int'(k) - 30];
		else if (k >= 7'h2B && k <= 7'h35)
			c = bottom_row[int'(k) - 43];
		else if (k == KEY_SPACE)
			c = " ";
		// Letters follow shift XOR caps; symbols follow shift alone.
		if (c >= "a" && c <= "z") begin
			if (shifted ^ caps)
				c = c - 8'h20;
		end else if (shifted && c != 8'h00) begin
			for (int i = 0; i < shift_from.len(); i++)
				if (shift_from[i] == c)
					c = shift_to[i];
		end
		return c[6:0];
	endfunction

	// Advances the predicted state by one scan byte and returns the key event it gives.
	function automatic key_result_t decode_scan_byte(input logic [7:0] b);
		key_result_t r;
		logic [6:0] k;
		logic is_break;
		k = b[6:0];
		is_break = b[7];
		r.kind = EV_NONE;
		r.char_code = 7'h00;
		if (b == PREFIX_BYTE) begin
			ext_pending = 1'b1;
		end else if (ext_pending) begin
			ext_pending = 1'b0;
			if (!is_break)
				r.kind = nav_event(k);
		end else if (k == KEY_LSHIFT) begin
			lshift_held = !is_break;
		end else if (k == KEY_RSHIFT) begin
			rshift_held = !is_break;
		end else if (k == KEY_CTRL) begin
			ctrl_held = !is_break;
		end else if (b == ESC_RELEASE) begin
			r.kind = EV_EXIT;
		end else if (!is_break) begin
			if (k == KEY_CAPS) begin
				caps_locked = !caps_locked;
				r.kind = EV_CAPS;
			end else if (k == KEY_F1) begin
				r.kind = EV_HELP;
			end else if (k == KEY_F2 || (ctrl_held && k == KEY_S)) begin
				r.kind = EV_SAVE;
			end else if (ctrl_held && k == KEY_Z) begin
				r.kind = EV_UNDO;
			end else if (k == KEY_BKSP) begin
				r.kind = EV_BACKSPACE;
			end else if (k == KEY_ENTER) begin
				r.kind = EV_CHAR;
				r.char_code = ASCII_LF;
			end else if (k == KEY_TAB) begin
				r.kind = EV_TAB;
			end else begin
				r.char_code = typed_char(k, lshift_held | rshift_held, caps_locked);
				if (r.char_code != 7'h00)
					r.kind = EV_CHAR;
			end
		end
		r.caps_on = caps_locked;
		return r;
	endfunction

	function automatic logic [6:0] random_nav_key();
		logic [6:0] k;
		case ($urandom_range(9))
			0: k = KEY_HOME;
			1: k = KEY_END;
			2: k = KEY_UP;
			3: k = KEY_DOWN;
			4: k = KEY_LEFT;
			5: k = KEY_RIGHT;
			6: k = KEY_PGUP;
			7: k = KEY_PGDN;
			8: k = KEY_INSERT;
			default: k = KEY_DELETE;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] random_modifier();
		logic [6:0] k;
		case ($urandom_range(2))
			0: k = KEY_LSHIFT;
			1: k = KEY_RSHIFT;
			default: k = KEY_CTRL;
		endcase
		return k;
	endfunction

	function automatic logic [6:0] random_command_key();
		logic [6:0] k;
		case ($urandom_range(5))
			0: k = KEY_F1;
			1: k = KEY_F2;
			2: k = KEY_ESC;
			3: k = KEY_BKSP;
			4: k = KEY_ENTER;
			default: k = KEY_TAB;
		endcase
		return k;
	endfunction

	// Queues mostly well-formed keystroke sequences with random keys, plus raw noise bytes.
	task automatic queue_keystrokes(input int count);
		int start;
		int sel;
		logic [6:0] k;
		start = scan_queue.size();
		while (scan_queue.size() - start < count) begin
			sel = $urandom_range(99);
			if (sel < 40) begin
				k = 7'($urandom_range(2, 57));
				scan_queue.push_back({1'b0, k});
				if ($urandom_range(1))
					scan_queue.push_back({1'b1, k});
			end else if (sel < 52) begin
				scan_queue.push_back({1'($urandom_range(1)), random_modifier()});
			end else if (sel < 58) begin
				scan_queue.push_back({1'b0, KEY_CAPS});
				scan_queue.push_back({1'b1, KEY_CAPS});
			end else if (sel < 72) begin
				scan_queue.push_back(PREFIX_BYTE);
				if ($urandom_range(9) == 0)
					scan_queue.push_back(PREFIX_BYTE);
				if ($urandom_range(3) == 0)
					k = 7'($urandom_range(127));
				else
					k = random_nav_key();
				scan_queue.push_back({1'($urandom_range(3) == 0), k});
			end else if (sel < 80) begin
				k = $urandom_range(1) ? KEY_S : KEY_Z;
				scan_queue.push_back({1'b0, KEY_CTRL});
				scan_queue.push_back({1'b0, k});
				scan_queue.push_back({1'b1, k});
				scan_queue.push_back({1'b1, KEY_CTRL});
			end else if (sel < 86) begin
				k = random_command_key();
				scan_queue.push_back({1'b0, k});
				scan_queue.push_back({1'b1, k});
			end else begin
				scan_queue.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	// Waits until every queued byte is accepted and every key event has come out.
	task automatic wait_drained();
		while (scan_queue.size() != 0 || in_valid || expected_events.size() != 0)
			@(negedge clk);
	endtask

	// Driver: offers queued bytes and predicts each accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_events.push_back(decode_scan_byte(scan_byte));
			if (!in_valid || !in_stall) begin
				if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					scan_byte <= scan_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_count <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Monitor: compares each output transaction with the oldest predicted event.
	always @(posedge clk) begin
		key_result_t exp_ev;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected key event kind=%0d char=%0h caps=%0b",
					$realtime, event_kind, char_code, caps_on);
				error_count++;
			end else begin
				exp_ev = expected_events.pop_front();
				if (event_kind !== exp_ev.kind) begin
					$display("%0t: event_kind expected %0d actual %0d",
						$realtime, exp_ev.kind, event_kind);
					error_count++;
				end
				if (char_code !== exp_ev.char_code) begin
					$display("%0t: char_code expected %0h actual %0h",
						$realtime, exp_ev.char_code, char_code);
					error_count++;
				end
				if (caps_on !== exp_ev.caps_on) begin
					$display("%0t: caps_on expected %0b actual %0b",
						$realtime, exp_ev.caps_on, caps_on);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("scancode_set1_key_decoder_core_test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed bytes: field extremes, escape, modifiers, commands and prefix cases.
		send_idle_pct = 27;
		recv_idle_pct = 65;
		scan_queue.push_back(8'h00);
		scan_queue.push_back(8'hFF);
		scan_queue.push_back({1'b0, KEY_ESC});
		scan_queue.push_back(ESC_RELEASE);
		scan_queue.push_back({1'b0, KEY_LSHIFT});
		scan_queue.push_back({1'b0, KEY_ONE});
		scan_queue.push_back({1'b0, KEY_A});
		scan_queue.push_back({1'b1, KEY_LSHIFT});
		scan_queue.push_back({1'b0, KEY_CAPS});
		scan_queue.push_back({1'b0, KEY_RSHIFT});
		scan_queue.push_back({1'b0, KEY_A});
		scan_queue.push_back({1'b1, KEY_RSHIFT});
		scan_queue.push_back({1'b0, KEY_CTRL});
		scan_queue.push_back({1'b0, KEY_S});
		scan_queue.push_back({1'b0, KEY_Z});
		scan_queue.push_back({1'b0, KEY_E});
		scan_queue.push_back({1'b1, KEY_CTRL});
		scan_queue.push_back({1'b0, KEY_F1});
		scan_queue.push_back({1'b0, KEY_F2});
		scan_queue.push_back({1'b0, KEY_BKSP});
		scan_queue.push_back({1'b0, KEY_ENTER});
		scan_queue.push_back({1'b0, KEY_TAB});
		scan_queue.push_back(PREFIX_BYTE);
		scan_queue.push_back(PREFIX_BYTE);
		scan_queue.push_back({1'b0, KEY_DELETE});
		scan_queue.push_back(PREFIX_BYTE);
		scan_queue.push_back({1'b1, KEY_LSHIFT});
		scan_queue.push_back(8'h7F);
		scan_queue.push_back({1'b0, KEY_CAPS});
		queue_keystrokes(180);
		wait_drained();

		// The sender has paused until all events came out; now swap the idle rates.
		send_idle_pct = 65;
		recv_idle_pct = 27;
		queue_keystrokes(190);
		wait_drained();

		// No idling, with one long receiver hold-off while bytes keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_keystrokes(180);
		while (scan_queue.size() > 150)
			@(negedge clk);
		hold_toggle = !hold_toggle;
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("scancode_set1_key_decoder_core_test passed");
		else
			$display("scancode_set1_key_decoder_core_test failed");
		$finish;
	end

endmodule
